@@ src/tpob_pkg.sv @@
// Shared constants and types for the timed pulse output bank.
`default_nettype none

package tpob_pkg;

    // Number of output lines in the bank.
    localparam int NUM_OUTPUTS = 8;

    // Width of a line index and of a counter that can also hold the line count.
    localparam int IDX_W = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
    localparam int CNT_W = $clog2(NUM_OUTPUTS + 1);

    // Number of lines shown on the level bus.
    localparam int PIN_W = 8;

    // Command codes.
    localparam logic [2:0] FUNC_TICK        = 3'd0;
    localparam logic [2:0] FUNC_SET         = 3'd1;
    localparam logic [2:0] FUNC_SET_TIMEOUT = 3'd2;
    localparam logic [2:0] FUNC_SET_PULSED  = 3'd3;
    localparam logic [2:0] FUNC_READ        = 3'd4;

    // Configuration register map.
    localparam int          PADDR_W          = 3;
    localparam logic [2:0]  ADDR_PULSE_DELAY = 3'd0;
    localparam logic [15:0] PULSE_DELAY_RST  = 16'd500;

    // One line-memory entry: deadline (zero means disarmed) and toggles left.
    typedef struct packed {
        logic [31:0] deadline;
        logic [8:0]  toggles;
    } entry_t;

endpackage

`default_nettype wire

@@ src/timed_pulse_output_bank.sv @@
// Top level of the timed pulse output bank: command sequencer and line memory.
`default_nettype none

// Each request is one command. Set, set-with-timeout, set-pulsed and read
// go through these steps from acceptance to the next acceptance: latch the
// request, update the line, and load the result register once the result
// channel is free. A tick sweeps the deadlines and toggle counts, which live
// in a single-port-read memory with a registered read port, one line per
// cycle, reading the next line while writing back the current one. Line
// levels are kept in flip-flops so the level bus is always complete. The
// memory needs no clearing pass: a per-entry valid bit makes an entry read
// as disarmed until it is first written. The result register lets a new
// request be accepted while the previous result is still stalled.
module timed_pulse_output_bank (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Command channel.
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [2:0]                    func,
    input  wire logic [31:0]                   now_ms,
    input  wire logic [2:0]                    output_id,
    input  wire logic                          level,
    input  wire logic [31:0]                   timeout_ms,
    input  wire logic [7:0]                    pulse_pairs,
    // Result channel.
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [tpob_pkg::PIN_W-1:0]         pin_levels,
    output logic                               read_level,
    // Configuration port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tpob_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMD  = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Configuration register.
    logic [15:0] pulse_delay_reg;
    logic        cfg_wr;

    // Latched request.
    logic [2:0]  func_reg;
    logic [31:0] now_reg;
    logic [2:0]  id_reg;
    logic        cmd_level_reg;
    logic [31:0] timeout_reg;
    logic [7:0]  pairs_reg;

    // Line state: levels in flip-flops, deadlines and toggles in memory.
    logic [tpob_pkg::NUM_OUTPUTS-1:0] level_reg;
    logic [tpob_pkg::NUM_OUTPUTS-1:0] ent_vld_reg;
    tpob_pkg::entry_t                 mem [tpob_pkg::NUM_OUTPUTS];
    tpob_pkg::entry_t                 rdata_reg;
    logic                             rvld_reg;

    // Sweep control.
    logic [tpob_pkg::CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic [tpob_pkg::IDX_W-1:0] proc_idx_reg;
    logic                       proc_vld_reg, proc_vld_next;
    logic                       rd_level_reg, rd_level_next;

    // Result register.
    logic                       out_valid_reg;
    logic [tpob_pkg::PIN_W-1:0] pin_levels_reg;
    logic                       read_level_reg;

    // Datapath signals.
    logic                       in_acc;
    logic                       id_ok;
    logic [tpob_pkg::IDX_W-1:0] cmd_idx;
    logic [tpob_pkg::IDX_W-1:0] raddr;
    logic                       scan_rd;
    tpob_pkg::entry_t           cur;
    logic                       armed;
    logic [31:0]                sum_delay;
    logic [31:0]                sum_timeout;
    logic                       mem_we;
    logic [tpob_pkg::IDX_W-1:0] waddr;
    tpob_pkg::entry_t           wdata;
    logic                       lvl_we;
    logic [tpob_pkg::IDX_W-1:0] lvl_widx;
    logic                       lvl_wval;
    logic [tpob_pkg::PIN_W-1:0] pins_now;
    logic                       out_free;

    // Configuration port: always ready, one register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == tpob_pkg::ADDR_PULSE_DELAY);
    assign prdata = (paddr == tpob_pkg::ADDR_PULSE_DELAY) ? {16'b0, pulse_delay_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_delay_reg <= tpob_pkg::PULSE_DELAY_RST;
        end
        else if (cfg_wr)
        begin
            pulse_delay_reg <= pwdata[15:0];
        end
    end

    // Request handshake.
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Latch the request payload.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            func_reg      <= func;
            now_reg       <= now_ms;
            id_reg        <= output_id;
            cmd_level_reg <= level;
            timeout_reg   <= timeout_ms;
            pairs_reg     <= pulse_pairs;
        end
    end

    assign id_ok   = (32'(id_reg) < 32'(tpob_pkg::NUM_OUTPUTS));
    assign cmd_idx = tpob_pkg::IDX_W'(id_reg);

    // Sweep read side: one line read per cycle while lines remain.
    assign scan_rd = (state_reg == S_SCAN) && (32'(scan_cnt_reg) < 32'(tpob_pkg::NUM_OUTPUTS));
    assign raddr   = scan_cnt_reg[tpob_pkg::IDX_W-1:0];

    // Entry under processing; an entry never written reads as disarmed.
    assign cur         = rvld_reg ? rdata_reg : '0;
    assign armed       = (cur.deadline != 32'b0) && (now_reg >= cur.deadline);
    assign sum_delay   = now_reg + {16'b0, pulse_delay_reg};
    assign sum_timeout = now_reg + timeout_reg;

    // Write-back selection for commands and for the tick sweep.
    always_comb
    begin
        mem_we   = 1'b0;
        waddr    = cmd_idx;
        wdata    = '0;
        lvl_we   = 1'b0;
        lvl_widx = cmd_idx;
        lvl_wval = cmd_level_reg;
        case (state_reg)
            S_CMD:
            begin
                if (id_ok)
                begin
                    case (func_reg)
                        tpob_pkg::FUNC_SET:
                        begin
                            mem_we = 1'b1;
                            lvl_we = 1'b1;
                        end
                        tpob_pkg::FUNC_SET_TIMEOUT:
                        begin
                            mem_we         = 1'b1;
                            lvl_we         = 1'b1;
                            wdata.deadline = sum_timeout;
                        end
                        tpob_pkg::FUNC_SET_PULSED:
                        begin
                            mem_we         = 1'b1;
                            lvl_we         = 1'b1;
                            wdata.deadline = sum_delay;
                            wdata.toggles  = {pairs_reg, 1'b0};
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                waddr    = proc_idx_reg;
                lvl_widx = proc_idx_reg;
                if (proc_vld_reg && armed)
                begin
                    mem_we = 1'b1;
                    lvl_we = 1'b1;
                    if (cur.toggles != 9'b0)
                    begin
                        wdata.deadline = sum_delay;
                        wdata.toggles  = cur.toggles - 9'd1;
                        lvl_wval       = !level_reg[proc_idx_reg];
                    end
                    else
                    begin
                        lvl_wval = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Line memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (scan_rd)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // Entry valid bits, read valid and line levels.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_vld_reg <= '0;
            rvld_reg    <= 1'b0;
            level_reg   <= '0;
        end
        else
        begin
            if (mem_we)
            begin
                ent_vld_reg[waddr] <= 1'b1;
            end
            if (scan_rd)
            begin
                rvld_reg <= ent_vld_reg[raddr];
            end
            if (lvl_we)
            begin
                level_reg[lvl_widx] <= lvl_wval;
            end
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        proc_vld_next = 1'b0;
        rd_level_next = rd_level_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    scan_cnt_next = '0;
                    rd_level_next = 1'b0;
                    state_next    = (func == tpob_pkg::FUNC_TICK) ? S_SCAN : S_CMD;
                end
            end
            S_CMD:
            begin
                if (func_reg == tpob_pkg::FUNC_READ && id_ok)
                begin
                    rd_level_next = level_reg[cmd_idx];
                end
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (scan_rd)
                begin
                    proc_vld_next = 1'b1;
                    scan_cnt_next = scan_cnt_reg + tpob_pkg::CNT_W'(1);
                end
                else if (proc_vld_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_cnt_reg <= '0;
            proc_vld_reg <= 1'b0;
            rd_level_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            proc_vld_reg <= proc_vld_next;
            rd_level_reg <= rd_level_next;
        end
    end

    // Line index that travels with the read data.
    always_ff @(posedge clk)
    begin
        if (scan_rd)
        begin
            proc_idx_reg <= raddr;
        end
    end

    // Level bus view of the line levels.
    for (genvar i = 0; i < tpob_pkg::PIN_W; i++)
    begin : g_pins
        if (i < tpob_pkg::NUM_OUTPUTS)
        begin : g_on
            assign pins_now[i] = level_reg[i];
        end
        else
        begin : g_off
            assign pins_now[i] = 1'b0;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            pin_levels_reg <= pins_now;
            read_level_reg <= rd_level_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pin_levels = pin_levels_reg;
    assign read_level = read_level_reg;

    // A new result only ever follows a finished request.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result appeared without a finished request");

    // Read data is only processed during a sweep.
    a_proc_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        proc_vld_reg |-> (state_reg == S_SCAN))
        else $error("line processed outside a tick sweep");

    // Write-back never hits the line being read in the same cycle.
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && scan_rd) |-> (waddr != raddr))
        else $error("read and write of the same line overlap");

    // The sweep counter never passes the line count.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(scan_cnt_reg) <= 32'(tpob_pkg::NUM_OUTPUTS))
        else $error("sweep counter out of range");

    // A stalled result holds its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_valid_reg && out_stall) |-> $stable(pin_levels_reg))
        else $error("stalled result changed");

endmodule

`default_nettype wire
